// ===== hdl/pgnl_pkg.sv =====
package pgnl_pkg;

    // default sizes of the grid
    localparam int DEF_GRID_CELLS = 32;
    localparam int DEF_YAW_CELLS  = 64;
    localparam int DEF_MODES      = 4;
    localparam int DEF_ID_BITS    = 16;

    // operation codes
    localparam logic [1:0] OP_SET       = 2'd0;
    localparam logic [1:0] OP_LOOKUP    = 2'd1;
    localparam logic [1:0] OP_CLR_SAME  = 2'd2;
    localparam logic [1:0] OP_CLR_ALL   = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_XY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_YAW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_TURN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_USED  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MODES_USED = 3'd7;

    // status codes
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] yaw;
        logic [1:0]         drive_mode;
        logic [15:0]        node_id;
    } t_in_item;

    typedef struct packed {
        logic [15:0] found_id;
        logic        status;
    } t_out_item;

endpackage

// ===== hdl/pgnl_ram.sv =====
module pgnl_ram
    import pgnl_pkg::*;
#(
    parameter int WIDTH = DEF_ID_BITS,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, read before write, registered read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pose_grid_node_lookup.sv =====
// the x, y and yaw cells are each found in offset, magnitude, multiply and check states
// through one shared 32x32 multiplier; then the table entry is read and, for a pose inside
// the box, taken as the result and updated as the operation asks; a new item is taken only
// in idle, so the input stalls until the result is loaded into the output register
// clear all writes one table entry per cycle; reset (synchronous, active low) loads register
// defaults, then the table of 2**(address bits) entries (262144 by default) is cleared while the input is stalled
module pose_grid_node_lookup
    import pgnl_pkg::*;
#(
    parameter int GRID_CELLS = DEF_GRID_CELLS,
    parameter int YAW_CELLS  = DEF_YAW_CELLS,
    parameter int MODES      = DEF_MODES,
    parameter int ID_BITS    = DEF_ID_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int XW    = $clog2(GRID_CELLS);
    localparam int YW    = $clog2(YAW_CELLS);
    localparam int MW    = (MODES > 1) ? $clog2(MODES) : 1;
    localparam int AW    = 2 * XW + YW + MW;
    localparam int DEPTH = 2 ** AW;
    localparam int CMPW  = 12;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_OFF   = 4'd1;
    localparam logic [3:0] S_MAG   = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_WB    = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;
    localparam logic [3:0] S_CLEAR = 4'd8;

    // axis being quantized
    localparam logic [1:0] STEP_X = 2'd0;
    localparam logic [1:0] STEP_Y = 2'd1;
    localparam logic [1:0] STEP_A = 2'd2;

    // configuration registers
    logic signed [31:0] r_center_x;
    logic signed [31:0] r_center_y;
    logic [30:0]        r_box_size;
    logic [31:0]        r_scale_xy;
    logic [31:0]        r_scale_yaw;
    logic [5:0]         r_yaw_turn;
    logic [5:0]         r_grid_used;
    logic [2:0]         r_modes_used;

    // sequencer and datapath registers
    logic [3:0]         r_state;
    logic [1:0]         r_step;
    logic               r_init;
    t_in_item           r_item;
    logic               r_oob;
    logic signed [34:0] r_off;
    logic [31:0]        r_mag;
    logic               r_neg;
    logic               r_big;
    logic [63:0]        r_prod;
    logic [XW-1:0]      r_cx;
    logic [XW-1:0]      r_cy;
    logic [YW-1:0]      r_ca;
    logic [AW-1:0]      r_clr_idx;
    logic [15:0]        r_found;
    logic               r_status;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic [CMPW-1:0]    gmax;
    logic [CMPW-1:0]    mmax;
    logic signed [31:0] sel_pos;
    logic signed [31:0] sel_center;
    logic signed [34:0] off_sum;
    logic signed [34:0] mag_full;
    logic [31:0]        sel_scale;
    logic [38:0]        q_xy;
    logic [39:0]        q_a;
    logic               xy_ok;
    logic               a_ok;
    logic [5:0]         a_cell;
    logic [AW-1:0]      idx;
    logic [ID_BITS-1:0] id_m;
    logic [ID_BITS-1:0] ram_rdata;
    logic [ID_BITS-1:0] ram_wdata;
    logic [AW-1:0]      ram_addr;
    logic               ram_we;
    logic               out_free;

    // bounds in use
    assign gmax = (CMPW'(r_grid_used) < CMPW'(GRID_CELLS)) ? CMPW'(r_grid_used)
                                                           : CMPW'(GRID_CELLS);
    assign mmax = (CMPW'(r_modes_used) < CMPW'(MODES)) ? CMPW'(r_modes_used)
                                                       : CMPW'(MODES);

    // doubled corner offset: 2*pos - 2*center + size
    assign sel_pos    = (r_step == STEP_Y) ? r_item.pos_y : r_item.pos_x;
    assign sel_center = (r_step == STEP_Y) ? r_center_y : r_center_x;
    assign off_sum    = {{2{sel_pos[31]}}, sel_pos, 1'b0}
                      - {{2{sel_center[31]}}, sel_center, 1'b0}
                      + {4'b0000, r_box_size};
    assign mag_full   = r_off[34] ? -r_off : r_off;
    assign sel_scale  = (r_step == STEP_A) ? r_scale_yaw : r_scale_xy;

    // x / y cell check, truncation toward zero
    assign q_xy  = r_prod[63:25];
    assign xy_ok = !r_big && (q_xy < 39'(gmax)) && (!r_neg || (q_xy == 39'd0));

    // yaw cell check, negative cells wrapped by one turn
    assign q_a = r_prod[63:24];
    always_comb begin
        if (r_neg && (q_a != 40'd0)) begin
            a_cell = r_yaw_turn - q_a[5:0];
            a_ok   = (q_a <= 40'(r_yaw_turn)) && (40'(a_cell) < 40'(YAW_CELLS));
        end else begin
            a_cell = q_a[5:0];
            a_ok   = (q_a <= 40'(r_yaw_turn)) && (q_a < 40'(YAW_CELLS));
        end
    end

    assign idx      = {r_cx, r_cy, r_ca, MW'(r_item.drive_mode)};
    assign id_m     = ID_BITS'(r_item.node_id);
    assign out_free = !r_out_valid || !i_out_stall;

    // table port control
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = idx;
        ram_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr_idx;
            end
            S_WB: begin
                if (r_item.operation == OP_SET) begin
                    ram_we    = 1'b1;
                    ram_wdata = id_m;
                end else if (r_item.operation == OP_CLR_SAME && ram_rdata == id_m) begin
                    ram_we = 1'b1;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    pgnl_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= 32'sd0;
            r_center_y   <= 32'sd0;
            r_box_size   <= 31'd32768;
            r_scale_xy   <= 32'd4194304;
            r_scale_yaw  <= 32'd16384;
            r_yaw_turn   <= 6'd36;
            r_grid_used  <= 6'd32;
            r_modes_used <= 3'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTER_X:   r_center_x   <= i_cfg_data;
                CFG_CENTER_Y:   r_center_y   <= i_cfg_data;
                CFG_BOX_SIZE:   r_box_size   <= i_cfg_data[30:0];
                CFG_SCALE_XY:   r_scale_xy   <= i_cfg_data;
                CFG_SCALE_YAW:  r_scale_yaw  <= i_cfg_data;
                CFG_YAW_TURN:   r_yaw_turn   <= i_cfg_data[5:0];
                CFG_GRID_USED:  r_grid_used  <= i_cfg_data[5:0];
                CFG_MODES_USED: r_modes_used <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_init    <= 1'b1;
            r_step    <= STEP_X;
            r_clr_idx <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_step    <= STEP_X;
                        r_clr_idx <= '0;
                        r_state   <= (i_in_data.operation == OP_CLR_ALL) ? S_CLEAR : S_OFF;
                    end
                end
                S_OFF:   r_state <= S_MAG;
                S_MAG:   r_state <= S_MUL;
                S_MUL:   r_state <= S_CHK;
                S_CHK: begin
                    if (r_step == STEP_A) begin
                        r_state <= S_RD;
                    end else begin
                        r_step  <= r_step + 2'd1;
                        r_state <= S_OFF;
                    end
                end
                S_RD:    r_state <= r_oob ? S_DONE : S_WB;
                S_WB:    r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + AW'(1);
                    if (r_clr_idx == '1) begin
                        r_init  <= 1'b0;
                        r_state <= r_init ? S_IDLE : S_DONE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath: operands, shared multiplier, cell checks, result
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item   <= i_in_data;
                r_oob    <= CMPW'(i_in_data.drive_mode) >= mmax;
                r_found  <= 16'd0;
                r_status <= STATUS_DONE;
            end
            S_OFF: begin
                r_off <= (r_step == STEP_A) ? 35'(r_item.yaw) : off_sum;
            end
            S_MAG: begin
                r_neg <= r_off[34];
                r_mag <= mag_full[31:0];
                r_big <= (mag_full[33:32] != 2'b00) && (sel_scale != 32'd0);
            end
            S_MUL: begin
                r_prod <= r_mag * sel_scale;
            end
            S_CHK: begin
                case (r_step)
                    STEP_X: begin
                        r_cx <= XW'(q_xy);
                        if (!xy_ok) r_oob <= 1'b1;
                    end
                    STEP_Y: begin
                        r_cy <= XW'(q_xy);
                        if (!xy_ok) r_oob <= 1'b1;
                    end
                    default: begin
                        r_ca <= YW'(a_cell);
                        if (!a_ok) r_oob <= 1'b1;
                    end
                endcase
            end
            S_RD: begin
                if (r_oob) begin
                    r_status <= STATUS_OUTSIDE;
                end
            end
            S_WB: begin
                r_found <= 16'(ram_rdata);
            end
            default: begin
            end
        endcase
    end

    // output register, loaded when the previous result has gone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_data.found_id <= r_found;
            r_out_data.status   <= r_status;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
